[src/itad_pkg.sv]
// shared constants and helpers for the integer to ascii digit converter
`default_nettype none
package itad_pkg;

    // default width of the value that is converted
    localparam int unsigned VALUE_WIDTH_DEF = 63;

    // digits of a 32-bit hex word
    localparam int unsigned HEX_DIGITS = 8;

    // mode codes
    localparam logic [1:0] MODE_DEC    = 2'd0;
    localparam logic [1:0] MODE_HEX_LO = 2'd1;
    localparam logic [1:0] MODE_HEX_UP = 2'd2;

    // ascii offsets
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_UPPER_OF = 8'h37;
    localparam logic [7:0] CHAR_LOWER_OF = 8'h57;

    // decimal digits of the largest value of a given width
    function automatic int unsigned dec_digits(input int unsigned w);
        longint unsigned v;
        int unsigned     n;
        int              i;
        v = (w >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << w) - 64'd1);
        n = 1;
        for (i = 0; i < 20; i++) begin
            if (v >= 64'd10) begin
                v = v / 64'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    // digit slots in the shift register, enough for decimal and hex
    function automatic int unsigned num_digits(input int unsigned w);
        int unsigned d;
        d = dec_digits(w);
        return (d > HEX_DIGITS) ? d : HEX_DIGITS;
    endfunction

    // ascii code of one digit
    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CHAR_ZERO + {4'd0, d};
        end else if (upper) begin
            r = CHAR_UPPER_OF + {4'd0, d};
        end else begin
            r = CHAR_LOWER_OF + {4'd0, d};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[src/itad_if.sv]
// valid/ready channels for the value input and the digit output
`default_nettype none
interface itad_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [62:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface itad_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  digit_char;
    logic        last;
    logic [4:0]  digit_count;
    logic [31:0] printed_total;

    modport source (output valid, output digit_char, output last, output digit_count,
                    output printed_total, input ready);
    modport sink   (input valid, input digit_char, input last, input digit_count,
                    input printed_total, output ready);
endinterface
`default_nettype wire

[src/itad_dabble.sv]
// one shift-and-add-3 step of the binary to bcd conversion
`default_nettype none
module itad_dabble #(
    parameter int unsigned NDIG = itad_pkg::num_digits(itad_pkg::VALUE_WIDTH_DEF)
) (
    input  wire logic [NDIG*4-1:0] i_dig,
    input  wire logic              i_bit,
    output logic      [NDIG*4-1:0] o_dig
);

    localparam int unsigned DW = NDIG * 4;

    logic [DW-1:0] w_adj;

    // add 3 to every digit of 5 or more
    for (genvar g = 0; g < NDIG; g++) begin : g_adj
        assign w_adj[g*4 +: 4] = (i_dig[g*4 +: 4] >= 4'd5) ? (i_dig[g*4 +: 4] + 4'd3)
                                                           : i_dig[g*4 +: 4];
    end

    // shift in the next binary bit
    assign o_dig = {w_adj[DW-2:0], i_bit};

endmodule
`default_nettype wire

[src/integer_to_ascii_digits.sv]
// Converts a value to ascii decimal or hex digits, most significant first.
// Decimal: after the accept, a bit-serial shift-add-3 conversion runs over the VALUE_WIDTH
// bits, then leading zero digit slots are skipped (at least one digit is kept) and the
// digits are emitted, each held while the output stalls. Hex loads the low 32 bits
// straight into the digit slots and skips the conversion. One value at a time.
// Synchronous active-low reset clears the control state, output valid and the char count.
`default_nettype none
module integer_to_ascii_digits #(
    parameter int unsigned VALUE_WIDTH = itad_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itad_in_if.sink     i_in,
    itad_out_if.source  o_out
);

    localparam int unsigned NDIG = itad_pkg::num_digits(VALUE_WIDTH);
    localparam int unsigned DW   = NDIG * 4;
    localparam int unsigned HW   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int unsigned BW   = $clog2(VALUE_WIDTH);
    localparam int unsigned CW   = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BW-1:0]        r_bit, n_bit;
    logic [DW-1:0]        r_dig, n_dig;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_total, n_total;
    logic                 r_upper, n_upper;
    logic [31:0]          r_printed, n_printed;
    logic                 r_o_valid, n_o_valid;
    logic [7:0]           r_char, n_char;
    logic                 r_last, n_last;
    logic [4:0]           r_count, n_count;
    logic [31:0]          r_ptotal, n_ptotal;

    logic [DW-1:0]        w_dabbled;
    logic [3:0]           w_top;
    logic                 w_out_free;
    logic [31:0]          w_inc;

    // bcd step
    itad_dabble #(.NDIG(NDIG)) u_dabble (
        .i_dig (r_dig),
        .i_bit (r_bin[VALUE_WIDTH-1]),
        .o_dig (w_dabbled)
    );

    assign w_top      = r_dig[DW-1 -: 4];
    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_inc      = (r_printed == 32'hFFFF_FFFF) ? r_printed : (r_printed + 32'd1);

    // next state
    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bit     = r_bit;
        n_dig     = r_dig;
        n_cnt     = r_cnt;
        n_total   = r_total;
        n_upper   = r_upper;
        n_printed = r_printed;
        n_o_valid = r_o_valid && !o_out.ready;
        n_char    = r_char;
        n_last    = r_last;
        n_count   = r_count;
        n_ptotal  = r_ptotal;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_upper = i_in.mode[1];
                    n_cnt   = CW'(NDIG);
                    if (i_in.mode == itad_pkg::MODE_DEC) begin
                        n_bin   = i_in.value[VALUE_WIDTH-1:0];
                        n_dig   = '0;
                        n_bit   = BW'(VALUE_WIDTH - 1);
                        n_state = S_CONV;
                    end else begin
                        n_dig   = DW'(i_in.value[HW-1:0]);
                        n_state = S_SKIP;
                    end
                end
            end
            S_CONV: begin
                n_dig = w_dabbled;
                n_bin = r_bin << 1;
                n_bit = r_bit - BW'(1);
                if (r_bit == '0) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zero digits, keep at least one
                if (w_top == 4'd0 && r_cnt != CW'(1)) begin
                    n_dig = r_dig << 4;
                    n_cnt = r_cnt - CW'(1);
                end else begin
                    n_total = r_cnt;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_char    = itad_pkg::digit_ascii(w_top, r_upper);
                    n_last    = (r_cnt == CW'(1));
                    n_count   = 5'(r_total);
                    n_ptotal  = w_inc;
                    n_printed = w_inc;
                    n_dig     = r_dig << 4;
                    n_cnt     = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_printed <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_printed <= n_printed;
            r_o_valid <= n_o_valid;
        end
        r_bin    <= n_bin;
        r_bit    <= n_bit;
        r_dig    <= n_dig;
        r_cnt    <= n_cnt;
        r_total  <= n_total;
        r_upper  <= n_upper;
        r_char   <= n_char;
        r_last   <= n_last;
        r_count  <= n_count;
        r_ptotal <= n_ptotal;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_o_valid;
    assign o_out.digit_char    = r_char;
    assign o_out.last          = r_last;
    assign o_out.digit_count   = r_count;
    assign o_out.printed_total = r_ptotal;

endmodule
`default_nettype wire

[src/itad_checker.sv]
// port-level checks for the digit converter, bound to the top level
`default_nettype none
module itad_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_out_last,
    input wire logic [7:0] i_out_digit_char,
    input wire logic [4:0] i_out_digit_count
);

    // an accepted value keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accepting a value");

    // no new value while digits of the current one remain
    a_busy_midvalue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready while a value is half emitted");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_digit_char) && $stable(i_out_last))
        else $error("stalled output word changed");

    // every word reports at least one digit
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_digit_count != 5'd0)
        else $error("digit count of zero");

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind integer_to_ascii_digits itad_checker u_itad_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_last        (o_out.last),
    .i_out_digit_char  (o_out.digit_char),
    .i_out_digit_count (o_out.digit_count)
);
`default_nettype wire

[verif/integer_to_ascii_digits_checker.sv]
// checker: predicts the digit words of every accepted value and compares them
`timescale 1ns / 1ps
module integer_to_ascii_digits_checker #(
    parameter int unsigned VALUE_WIDTH = itad_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itad_in_if          i_in_mon,
    itad_out_if         i_out_mon,
    output int unsigned o_error_count,
    output int unsigned o_digits_pending
);

    localparam logic [63:0] WIDTH_MASK  = (64'd1 << VALUE_WIDTH) - 64'd1;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
    localparam int unsigned MAX_DIGITS  = 20;
    localparam logic [7:0]  ASCII_ZERO  = 8'h30;
    localparam logic [7:0]  ASCII_UP_A  = 8'h41;
    localparam logic [7:0]  ASCII_LO_A  = 8'h61;

    typedef struct packed {
        logic [7:0]  digit_char;
        logic        last;
        logic [4:0]  digit_count;
        logic [31:0] printed_total;
    } t_digit_word;

    t_digit_word   expected_digits[$];
    logic [31:0]   chars_printed = '0;
    int unsigned   error_count   = 0;

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        error_count++;
        $display("%0t ns itad: %s got %0h want %0h", $time, what, got, want);
    endtask

    // spell one value into digit words, most significant first
    task automatic spell_value(input logic [1:0] mode, input logic [62:0] value);
        logic [63:0] rest;
        logic [31:0] hex_word;
        logic [3:0]  nib;
        logic [7:0]  rev [MAX_DIGITS];
        int          n;
        int          k;
        t_digit_word word;
        rest = {1'b0, value} & WIDTH_MASK;
        n    = 0;
        if (mode == itad_pkg::MODE_DEC) begin
            do begin
                rev[n] = ASCII_ZERO + 8'(rest % 64'd10);
                rest   = rest / 64'd10;
                n++;
            end while (rest != 64'd0 && n < MAX_DIGITS);
        end else begin
            // bit 1 picks uppercase, so the unused code behaves as uppercase hex
            hex_word = rest[31:0];
            do begin
                nib = hex_word[3:0];
                if (nib < 4'd10) begin
                    rev[n] = ASCII_ZERO + 8'(nib);
                end else if (mode[1]) begin
                    rev[n] = ASCII_UP_A + 8'(nib) - 8'd10;
                end else begin
                    rev[n] = ASCII_LO_A + 8'(nib) - 8'd10;
                end
                hex_word = hex_word >> 4;
                n++;
            end while (hex_word != 32'd0 && n < MAX_DIGITS);
        end
        for (k = 0; k < n; k++) begin
            // running count sticks at its maximum
            if (chars_printed != COUNT_MAX) begin
                chars_printed++;
            end
            word.digit_char    = rev[n - 1 - k];
            word.last          = (k == n - 1);
            word.digit_count   = 5'(n);
            word.printed_total = chars_printed;
            expected_digits.push_back(word);
        end
    endtask

    // compare one accepted output word with the oldest expectation
    task automatic check_word();
        t_digit_word want;
        if (expected_digits.size() == 0) begin
            report_mismatch("word with nothing expected, char", i_out_mon.digit_char, 0);
        end else begin
            want = expected_digits.pop_front();
            if (i_out_mon.digit_char !== want.digit_char)
                report_mismatch("digit_char", i_out_mon.digit_char, want.digit_char);
            if (i_out_mon.last !== want.last)
                report_mismatch("last", i_out_mon.last, want.last);
            if (i_out_mon.digit_count !== want.digit_count)
                report_mismatch("digit_count", i_out_mon.digit_count, want.digit_count);
            if (i_out_mon.printed_total !== want.printed_total)
                report_mismatch("printed_total", i_out_mon.printed_total,
                                want.printed_total);
        end
    endtask

    // watch both channels at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chars_printed = '0;
            expected_digits.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                spell_value(i_in_mon.mode, i_in_mon.value);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                check_word();
            end
        end
        o_error_count    <= error_count;
        o_digits_pending <= expected_digits.size();
    end

endmodule

[verif/integer_to_ascii_digits_tb.sv]
// testbench top: clock, reset, value stimulus, digit sink and verdict
`timescale 1ns / 1ps
module integer_to_ascii_digits_tb;

    localparam logic [1:0]  MODE_UNUSED    = 2'd3;
    localparam int unsigned RANDOM_VALUES  = 150;
    localparam int unsigned HOLD_AT_WORD   = 300;
    localparam int unsigned HOLD_CYCLES    = 500;
    localparam int unsigned QUIET_LIMIT    = 3000;
    localparam int unsigned DRAIN_CYCLES   = 120;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    bit          idle_on = 1'b1;
    int unsigned error_count;
    int unsigned digits_pending;

    itad_in_if  in_if ();
    itad_out_if out_if ();

    integer_to_ascii_digits u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    integer_to_ascii_digits_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_mon         (in_if),
        .i_out_mon        (out_if),
        .o_error_count    (error_count),
        .o_digits_pending (digits_pending)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offer one value after a random gap and wait until it is taken
    task automatic send_value(input logic [1:0] mode, input logic [62:0] value);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.mode  <= mode;
        in_if.value <= value;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // random value of random bit length so that every digit count shows up
    function automatic logic [62:0] random_value();
        int unsigned     bits;
        logic [63:0]     raw;
        longint unsigned pow;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: begin
                random_value = raw[62:0];
            end
            1: begin
                // just below or at a power of ten
                pow = 1;
                repeat ($urandom_range(0, 18)) pow = pow * 10;
                random_value = 63'(pow - $urandom_range(0, 1));
            end
            default: begin
                bits = $urandom_range(1, 63);
                random_value = raw[62:0] & ((63'd1 << bits) - 63'd1);
            end
        endcase
    endfunction

    // value source, then drain and verdict
    initial begin : value_source
        int unsigned n;
        in_if.valid <= 1'b0;
        in_if.mode  <= itad_pkg::MODE_DEC;
        in_if.value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, single digits, digit count edges, every mode
        send_value(itad_pkg::MODE_DEC, 63'd0);
        send_value(itad_pkg::MODE_DEC, 63'd1);
        send_value(itad_pkg::MODE_DEC, 63'd9);
        send_value(itad_pkg::MODE_DEC, 63'd10);
        send_value(itad_pkg::MODE_DEC, 63'h7FFF_FFFF_FFFF_FFFF);
        send_value(itad_pkg::MODE_DEC, 63'd1000000000000000000);
        send_value(itad_pkg::MODE_DEC, 63'd999999999999999999);
        send_value(itad_pkg::MODE_DEC, 63'd4294967296);
        send_value(itad_pkg::MODE_DEC, 63'h5555_5555_5555_5555);
        send_value(itad_pkg::MODE_DEC, 63'h2AAA_AAAA_AAAA_AAAA);
        send_value(itad_pkg::MODE_HEX_LO, 63'd0);
        send_value(itad_pkg::MODE_HEX_LO, 63'hFFFF_FFFF);
        send_value(itad_pkg::MODE_HEX_UP, 63'hFFFF_FFFF);
        send_value(itad_pkg::MODE_HEX_LO, 63'h7FFF_FFFF_ABCD_EF01);
        send_value(itad_pkg::MODE_HEX_UP, 63'h2345_6789_ABCD_EF10);
        send_value(itad_pkg::MODE_HEX_UP, 63'h10);
        send_value(itad_pkg::MODE_HEX_LO, 63'h7FFF_FFFF_0000_0000);
        send_value(itad_pkg::MODE_HEX_UP, 63'h7FFF_FFFF_FFFF_FFFF);
        send_value(MODE_UNUSED, 63'hDEAD_BEEF);
        send_value(MODE_UNUSED, 63'd0);
        send_value(MODE_UNUSED, 63'h5A5A_5A5A_9);

        // random values, with a stretch of back-to-back traffic in the middle
        for (n = 0; n < RANDOM_VALUES; n++) begin
            idle_on <= !(n >= 60 && n < 90);
            send_value(2'($urandom_range(0, 3)), random_value());
        end
        in_if.valid <= 1'b0;

        // wait for every expected word, then let the block settle
        @(posedge i_clk);
        while (digits_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("integer_to_ascii_digits_tb: clean");
        end else begin
            $display("integer_to_ascii_digits_tb: errors");
        end
        $finish;
    end

    // digit sink with random stalls and one long hold-off
    initial begin : digit_sink
        int unsigned stall;
        int unsigned words_taken;
        words_taken = 0;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            // long hold-off so the block backs up and stalls its input
            if (words_taken == HOLD_AT_WORD) begin
                stall = HOLD_CYCLES;
            end
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            words_taken++;
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("integer_to_ascii_digits_tb: errors");
        $finish;
    end

endmodule
